@@ src/erd_pkg.sv @@
// Shared types, constants and series tables for the equirectangular distance core.
package erd_pkg;

   localparam int ANGLE_FRAC_BITS = 20;
   localparam int DIST_FRAC_BITS  = 10;
   localparam int LAT_W           = 28;
   localparam int LON_W           = 29;
   localparam int OUT_W           = 26;

   // Mean latitude is |lat1+lat2| in units of 2^-(A+1) degree.
   localparam int ANG_SHIFT = ANGLE_FRAC_BITS + 1;
   localparam logic [29:0] FULL_ANG    = 30'(64'd360 << ANG_SHIFT);
   localparam logic [29:0] HALF_ANG    = 30'(64'd180 << ANG_SHIFT);
   localparam logic [29:0] QUARTER_ANG = 30'(64'd90 << ANG_SHIFT);
   localparam logic [29:0] EIGHTH_ANG  = 30'(64'd45 << ANG_SHIFT);

   localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
   localparam logic [63:0] RAD_RND     = 64'd1 << (ANGLE_FRAC_BITS + 2);
   localparam int          RAD_SHIFT   = ANGLE_FRAC_BITS + 3;

   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
   localparam int          HORNER_TERMS = 7;

   localparam logic [63:0] KM_PER_DEG_X10 = 64'd1113;
   localparam logic [63:0] LEG_HALF       = 64'd5 << ANGLE_FRAC_BITS;
   localparam int          LEG_SHIFT      = ANGLE_FRAC_BITS + 1;

   // Reciprocals of 5 for the leg scaling; the quotient comes out low by at most one.
   localparam logic [31:0] RECIP5_Y       = 32'd3435973836;
   localparam int          RECIP5_Y_SHIFT = 34;
   localparam logic [32:0] RECIP5_X       = 33'd6871947673;
   localparam int          RECIP5_X_SHIFT = 35;

   localparam int SQRT_BITS = 32;

   typedef struct packed {
      logic [29:0] x;     // Q30 radians of the series argument
      logic        sel;   // sine series of the complement
      logic [29:0] dlon;  // |longitude difference|
      logic [29:0] y;     // north-south leg, units 2^-15 km
   } meta_type;

   // Divisor of Horner term k (7 down to 1).
   function automatic logic [7:0] horner_div(input int k, input logic sel);
      logic [7:0] d;
      case (k)
         7: d = sel ? 8'd210 : 8'd182;
         6: d = sel ? 8'd156 : 8'd132;
         5: d = sel ? 8'd110 : 8'd90;
         4: d = sel ? 8'd72  : 8'd56;
         3: d = sel ? 8'd42  : 8'd30;
         2: d = sel ? 8'd20  : 8'd12;
         1: d = sel ? 8'd6   : 8'd2;
         default: d = 8'd1;
      endcase
      return d;
   endfunction

   // floor(2^32 / divisor) of Horner term k.
   function automatic logic [31:0] horner_recip(input int k, input logic sel);
      logic [31:0] m;
      case (k)
         7: m = sel ? 32'd20452225  : 32'd23598721;
         6: m = sel ? 32'd27531841  : 32'd32537631;
         5: m = sel ? 32'd39045157  : 32'd47721858;
         4: m = sel ? 32'd59652323  : 32'd76695844;
         3: m = sel ? 32'd102261126 : 32'd143165576;
         2: m = sel ? 32'd214748364 : 32'd357913941;
         1: m = sel ? 32'd715827882 : 32'd2147483648;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

@@ src/erd_front.sv @@
// Front pipeline: differences, angle fold, radian scaling, x^2 and the north-south leg.
module erd_front import erd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [LAT_W-1:0] ref_lat,
   input  logic signed [LON_W-1:0] ref_lon,
   input  logic signed [LAT_W-1:0] tgt_lat,
   input  logic signed [LON_W-1:0] tgt_lon,
   output logic                    out_valid,
   output logic [29:0]             x2,
   output meta_type                meta
);

   // stage 1
   logic        v1_ff;
   logic [28:0] a1_ff, a1_in, dlat1_ff, dlat1_in;
   logic [29:0] dlon1_ff, dlon1_in;
   logic [28:0] lsum, ldif;
   logic [29:0] odif;

   always_comb begin
      lsum = {ref_lat[LAT_W-1], ref_lat} + {tgt_lat[LAT_W-1], tgt_lat};
      ldif = {ref_lat[LAT_W-1], ref_lat} - {tgt_lat[LAT_W-1], tgt_lat};
      odif = {ref_lon[LON_W-1], ref_lon} - {tgt_lon[LON_W-1], tgt_lon};
      a1_in    = lsum[28] ? (~lsum + 29'd1) : lsum;
      dlat1_in = ldif[28] ? (~ldif + 29'd1) : ldif;
      dlon1_in = odif[29] ? (~odif + 30'd1) : odif;
   end

   // stage 2: fold into [0,90] degrees, pick series
   logic        v2_ff, sel2_ff, sel2_in;
   logic [29:0] ang2_ff, ang2_in, a_h, a_q;
   logic [29:0] dlon2_ff;
   logic [32:0] yv2_ff, yv2_in;
   logic [63:0] ynum;

   always_comb begin
      a_h = ({1'b0, a1_ff} > HALF_ANG) ? (FULL_ANG - {1'b0, a1_ff}) : {1'b0, a1_ff};
      a_q = (a_h > QUARTER_ANG) ? (HALF_ANG - a_h) : a_h;
      sel2_in = a_q > EIGHTH_ANG;
      ang2_in = sel2_in ? (QUARTER_ANG - a_q) : a_q;
      ynum    = ((64'(dlat1_ff) * KM_PER_DEG_X10) << 15) + LEG_HALF;
      yv2_in  = 33'(ynum >> LEG_SHIFT);
   end

   // stage 3: radians, leg quotient estimate
   logic        v3_ff, sel3_ff;
   logic [29:0] x3_ff, x3_in, dlon3_ff, yq3_ff, yq3_in;
   logic [32:0] yv3_ff;
   logic [63:0] xprod;
   logic [64:0] yprod;

   always_comb begin
      xprod  = 64'(ang2_ff) * 64'(DEG2RAD_Q32) + RAD_RND;
      x3_in  = 30'(xprod >> RAD_SHIFT);
      yprod  = 65'(yv2_ff) * 65'(RECIP5_Y);
      yq3_in = 30'(yprod >> RECIP5_Y_SHIFT);
   end

   // stage 4: x^2, leg correction
   logic        v4_ff;
   logic [29:0] x2_ff, x2_in, y4_in;
   meta_type    meta4_ff;
   logic [59:0] xsq;
   logic [32:0] yrem;

   always_comb begin
      xsq   = 60'(x3_ff) * 60'(x3_ff);
      x2_in = 30'(xsq >> 30);
      yrem  = yv3_ff - 33'(yq3_ff) * 33'd5;
      y4_in = yq3_ff + ((yrem >= 33'd5) ? 30'd1 : 30'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff         <= a1_in;
         dlat1_ff      <= dlat1_in;
         dlon1_ff      <= dlon1_in;
         ang2_ff       <= ang2_in;
         sel2_ff       <= sel2_in;
         dlon2_ff      <= dlon1_ff;
         yv2_ff        <= yv2_in;
         x3_ff         <= x3_in;
         sel3_ff       <= sel2_ff;
         dlon3_ff      <= dlon2_ff;
         yv3_ff        <= yv2_ff;
         yq3_ff        <= yq3_in;
         x2_ff         <= x2_in;
         meta4_ff.x    <= x3_ff;
         meta4_ff.sel  <= sel3_ff;
         meta4_ff.dlon <= dlon3_ff;
         meta4_ff.y    <= y4_in;
      end
   end

   assign out_valid = v4_ff;
   assign x2        = x2_ff;
   assign meta      = meta4_ff;

endmodule

@@ src/erd_horner_step.sv @@
// One Horner term of the cosine/sine series: multiply, reciprocal divide, correct.
module erd_horner_step import erd_pkg::*; #(
   parameter int K = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [29:0] x2,
   input  logic [30:0] t,
   input  meta_type    meta,
   output logic        out_valid,
   output logic [29:0] x2_out,
   output logic [30:0] t_out,
   output meta_type    meta_out
);

   logic        va_ff, vb_ff, vc_ff;
   logic [29:0] pa_ff, pa_in, x2a_ff, pb_ff, qb_ff, qb_in, x2b_ff, x2c_ff;
   logic [30:0] tc_ff, tc_in;
   meta_type    ma_ff, mb_ff, mc_ff;
   logic [60:0] pprod;
   logic [61:0] qprod;
   logic [29:0] rem;
   logic [7:0]  dv;

   always_comb begin
      pprod = 61'(x2) * 61'(t);
      pa_in = 30'(pprod >> 30);
      qprod = 62'(pa_ff) * 62'(horner_recip(K, ma_ff.sel));
      qb_in = 30'(qprod >> 32);
      dv    = horner_div(K, mb_ff.sel);
      rem   = pb_ff - qb_ff * 30'(dv);
      tc_in = ONE_Q30 - 31'(qb_ff + ((rem >= 30'(dv)) ? 30'd1 : 30'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff  <= pa_in;
         x2a_ff <= x2;
         ma_ff  <= meta;
         pb_ff  <= pa_ff;
         qb_ff  <= qb_in;
         x2b_ff <= x2a_ff;
         mb_ff  <= ma_ff;
         tc_ff  <= tc_in;
         x2c_ff <= x2b_ff;
         mc_ff  <= mb_ff;
      end
   end

   assign out_valid = vc_ff;
   assign x2_out    = x2c_ff;
   assign t_out     = tc_ff;
   assign meta_out  = mc_ff;

endmodule

@@ src/erd_back.sv @@
// Back pipeline: |cos|, east-west leg, squares and their sum.
module erd_back import erd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [30:0] t,
   input  meta_type    meta,
   output logic        out_valid,
   output logic [62:0] sum
);

   logic [6:0]  v_ff;
   logic [30:0] c1_ff, c1_in;
   logic [29:0] dlon1_ff;
   logic [29:0] y_ff [1:5];
   logic [38:0] q2_ff, q2_in;
   logic [33:0] xv3_ff, xv3_in, xv4_ff;
   logic [30:0] xq4_ff, xq4_in, x5_ff, x5_in;
   logic [61:0] xx6_ff, xx6_in;
   logic [59:0] yy6_ff, yy6_in;
   logic [62:0] s7_ff, s7_in;
   logic [60:0] sprod, qprod;
   logic [63:0] xnum;
   logic [66:0] xprod;
   logic [33:0] xrem;

   always_comb begin
      sprod  = 61'(meta.x) * 61'(t);
      c1_in  = meta.sel ? 31'(sprod >> 30) : t;
      qprod  = 61'(dlon1_ff) * 61'(c1_ff);
      q2_in  = 39'(qprod >> 21);
      xnum   = ((64'(q2_ff) * KM_PER_DEG_X10) << 6) + LEG_HALF;
      xv3_in = 34'(xnum >> LEG_SHIFT);
      xprod  = 67'(xv3_ff) * 67'(RECIP5_X);
      xq4_in = 31'(xprod >> RECIP5_X_SHIFT);
      xrem   = xv4_ff - 34'(xq4_ff) * 34'd5;
      x5_in  = xq4_ff + ((xrem >= 34'd5) ? 31'd1 : 31'd0);
      xx6_in = 62'(x5_ff) * 62'(x5_ff);
      yy6_in = 60'(y_ff[5]) * 60'(y_ff[5]);
      s7_in  = 63'(xx6_ff) + 63'(yy6_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff    <= c1_in;
         dlon1_ff <= meta.dlon;
         y_ff[1]  <= meta.y;
         y_ff[2]  <= y_ff[1];
         y_ff[3]  <= y_ff[2];
         y_ff[4]  <= y_ff[3];
         y_ff[5]  <= y_ff[4];
         q2_ff    <= q2_in;
         xv3_ff   <= xv3_in;
         xv4_ff   <= xv3_ff;
         xq4_ff   <= xq4_in;
         x5_ff    <= x5_in;
         xx6_ff   <= xx6_in;
         yy6_ff   <= yy6_in;
         s7_ff    <= s7_in;
      end
   end

   assign out_valid = v_ff[6];
   assign sum       = s7_ff;

endmodule

@@ src/erd_sqrt_stage.sv @@
// One bit of the pipelined integer square root (restoring, remainder form).
module erd_sqrt_stage import erd_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [63:0]          rem,
   input  logic [SQRT_BITS-1:0] root,
   output logic                 out_valid,
   output logic [63:0]          rem_out,
   output logic [SQRT_BITS-1:0] root_out
);

   logic                 v_ff;
   logic [63:0]          rem_ff, rem_in, need;
   logic [SQRT_BITS-1:0] root_ff, root_in;

   always_comb begin
      need = (64'(root) << (BIT + 1)) + (64'd1 << (2 * BIT));
      if (rem >= need) begin
         rem_in  = rem - need;
         root_in = root | (SQRT_BITS'(1) << BIT);
      end else begin
         rem_in  = rem;
         root_in = root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = v_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;

endmodule

@@ src/equirectangular_distance_core.sv @@
// Equirectangular distance core: top level with register port, pipeline and output register.
// From an accepted req word to rsp_valid: 4 front, 21 series, 7 back and 32 root stages,
// then 1 output register. The series and the bit-per-stage root set the depth.
// Throughput: one word per cycle unless the output register is full and stalled.
// Reset (synchronous, active high) clears all valid bits and both reference
// registers to zero; a word in flight is dropped.
module equirectangular_distance_core import erd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [LAT_W-1:0] req_target_latitude,
   input  logic signed [LON_W-1:0] req_target_longitude,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [OUT_W-1:0]        rsp_distance,
   // register port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam logic REG_REF_LAT = 1'b0;
   localparam logic REG_REF_LON = 1'b1;

   // ---------------- register port ----------------
   logic signed [LAT_W-1:0] ref_lat_ff;
   logic signed [LON_W-1:0] ref_lon_ff;
   logic                    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lat_ff <= '0;
         ref_lon_ff <= '0;
      end else if (wr_en) begin
         case (paddr[2])
            REG_REF_LAT: ref_lat_ff <= pwdata[LAT_W-1:0];
            REG_REF_LON: ref_lon_ff <= pwdata[LON_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_REF_LAT: prdata = {{(32-LAT_W){1'b0}}, ref_lat_ff};
         REG_REF_LON: prdata = {{(32-LON_W){1'b0}}, ref_lon_ff};
         default:     prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   // The whole pipeline advances together. Hold it only when the last root stage
   // carries a word and the output register is full and stalled; a bubble at the
   // end lets upstream words keep moving while a result waits.
   logic en;
   logic last_valid;
   logic rsp_valid_ff;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign en        = !(last_valid && !out_free);
   assign req_ready = en;

   // ---------------- front ----------------
   logic        f_valid;
   logic [29:0] f_x2;
   meta_type    f_meta;

   erd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid && req_ready),
      .ref_lat   (ref_lat_ff),
      .ref_lon   (ref_lon_ff),
      .tgt_lat   (req_target_latitude),
      .tgt_lon   (req_target_longitude),
      .out_valid (f_valid),
      .x2        (f_x2),
      .meta      (f_meta)
   );

   // ---------------- series ----------------
   // Index 0 feeds the highest term; index HORNER_TERMS is the finished series.
   logic        h_valid [0:HORNER_TERMS];
   logic [29:0] h_x2    [0:HORNER_TERMS];
   logic [30:0] h_t     [0:HORNER_TERMS];
   meta_type    h_meta  [0:HORNER_TERMS];

   assign h_valid[0] = f_valid;
   assign h_x2[0]    = f_x2;
   assign h_t[0]     = ONE_Q30;
   assign h_meta[0]  = f_meta;

   for (genvar g = 0; g < HORNER_TERMS; g++) begin : g_term
      erd_horner_step #(.K(HORNER_TERMS - g)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (h_valid[g]),
         .x2        (h_x2[g]),
         .t         (h_t[g]),
         .meta      (h_meta[g]),
         .out_valid (h_valid[g+1]),
         .x2_out    (h_x2[g+1]),
         .t_out     (h_t[g+1]),
         .meta_out  (h_meta[g+1])
      );
   end

   // ---------------- legs and squares ----------------
   logic        b_valid;
   logic [62:0] b_sum;

   erd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (h_valid[HORNER_TERMS]),
      .t         (h_t[HORNER_TERMS]),
      .meta      (h_meta[HORNER_TERMS]),
      .out_valid (b_valid),
      .sum       (b_sum)
   );

   // ---------------- square root, one bit a stage ----------------
   logic                 s_valid [0:SQRT_BITS];
   logic [63:0]          s_rem   [0:SQRT_BITS];
   logic [SQRT_BITS-1:0] s_root  [0:SQRT_BITS];

   assign s_valid[0] = b_valid;
   assign s_rem[0]   = 64'(b_sum);
   assign s_root[0]  = '0;

   for (genvar g = 0; g < SQRT_BITS; g++) begin : g_root
      erd_sqrt_stage #(.BIT(SQRT_BITS - 1 - g)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (s_valid[g]),
         .rem       (s_rem[g]),
         .root      (s_root[g]),
         .out_valid (s_valid[g+1]),
         .rem_out   (s_rem[g+1]),
         .root_out  (s_root[g+1])
      );
   end

   assign last_valid = s_valid[SQRT_BITS];

   // ---------------- rounding and output register ----------------
   // Round the root to nearest, scale to output units, saturate.
   logic [SQRT_BITS:0]   root_rnd;
   logic [48:0]          dist_wide;
   logic [OUT_W-1:0]     dist_in, rsp_distance_ff;

   always_comb begin
      root_rnd  = {1'b0, s_root[SQRT_BITS]}
                + ((s_rem[SQRT_BITS] > 64'(s_root[SQRT_BITS])) ? 33'd1 : 33'd0);
      dist_wide = ((49'(root_rnd) << DIST_FRAC_BITS) + (49'd1 << 14)) >> 15;
      dist_in   = (dist_wide > 49'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : dist_wide[OUT_W-1:0];
   end

   // Load a finished word when the slot is free; drop valid once it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && last_valid) begin
         rsp_distance_ff <= dist_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   // ---------------- assertions ----------------
   // A word at the pipeline end must never be overrun while the output stalls.
   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (last_valid && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("pipeline advanced over a stalled result");

   // The finished series stays within (0, 1] in Q30.
   a_series_range : assert property (@(posedge clock) disable iff (reset)
      h_valid[HORNER_TERMS] |-> (h_t[HORNER_TERMS] <= ONE_Q30) && (h_t[HORNER_TERMS] != '0))
      else $error("series value out of range");

   // A floor root leaves a remainder of at most twice the root.
   a_root_rem : assert property (@(posedge clock) disable iff (reset)
      last_valid |-> (s_rem[SQRT_BITS] <= (65'(s_root[SQRT_BITS]) << 1)))
      else $error("square root remainder too large");

endmodule

@@ bench/equirectangular_distance_core_tb.sv @@
// Self-checking testbench for the equirectangular distance core.
`timescale 1ns / 1ps

module equirectangular_distance_core_tb;
   import erd_pkg::*;

   localparam logic [2:0] ADDR_REF_LAT = 3'd0;
   localparam logic [2:0] ADDR_REF_LON = 3'd4;
   localparam int LATENCY   = 65;
   localparam int CYCLE_CAP = 400000;
   localparam logic signed [LAT_W-1:0] LAT_MAX = 28'sd94371840;
   localparam logic signed [LON_W-1:0] LON_MAX = 29'sd188743680;

   // Fixed-point distance predictor; it mirrors the core's arithmetic.
   class distance_scoreboard;
      logic [LAT_W-1:0] ref_lat;
      logic [LON_W-1:0] ref_lon;
      logic [OUT_W-1:0] pending_dist[$];
      int errors;

      function new();
         ref_lat = '0;
         ref_lon = '0;
         errors = 0;
      endfunction

      static function longint unsigned abs_diff(longint v);
         return v < 0 ? longint'(-v) : longint'(v);
      endfunction

      static function longint unsigned horner(longint unsigned x, bit sine);
         longint unsigned x2, t;
         x2 = (x * x) >> 30;
         t = 64'd1 << 30;
         for (int k = 7; k >= 1; k--) begin
            if (sine)
               t = (64'd1 << 30) - ((x2 * t) >> 30) / longint'((2*k) * (2*k + 1));
            else
               t = (64'd1 << 30) - ((x2 * t) >> 30) / longint'((2*k - 1) * (2*k));
         end
         return sine ? (x * t) >> 30 : t;
      endfunction

      static function longint unsigned mag_cos(longint unsigned a);
         longint unsigned full, half, quarter, eighth, rnd;
         full = 64'd360 << 21;
         half = 64'd180 << 21;
         quarter = 64'd90 << 21;
         eighth = 64'd45 << 21;
         rnd = 64'd1 << 22;
         a = a % full;
         if (a > half) a = full - a;
         if (a > quarter) a = half - a;
         if (a <= eighth)
            return horner((a * 74961321 + rnd) >> 23, 1'b0);
         return horner(((quarter - a) * 74961321 + rnd) >> 23, 1'b1);
      endfunction

      static function longint unsigned root_rounded(longint unsigned s);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > s) b >>= 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         if (s > r) r++;
         return r;
      endfunction

      // Note an accepted target point and queue its distance.
      function void note_target(logic [LAT_W-1:0] lat, logic [LON_W-1:0] lon);
         longint l1, g1, l2, g2;
         longint unsigned dlat, dlon, c, y, q, x, r, d, den, hden;
         l1 = longint'(signed'(ref_lat));
         g1 = longint'(signed'(ref_lon));
         l2 = longint'(signed'(lat));
         g2 = longint'(signed'(lon));
         dlat = abs_diff(l1 - l2);
         dlon = abs_diff(g1 - g2);
         c = mag_cos(abs_diff(l1 + l2));
         den = 64'd10 << 20;
         hden = 64'd5 << 20;
         y = (dlat * 1113 * 32768 + hden) / den;
         q = (dlon * c) >> 21;
         x = (q * 1113 * 64 + hden) / den;
         r = root_rounded(x * x + y * y);
         d = ((r << DIST_FRAC_BITS) + (64'd1 << 14)) >> 15;
         if (d > (64'd1 << OUT_W) - 1) d = (64'd1 << OUT_W) - 1;
         pending_dist.push_back(d[OUT_W-1:0]);
      endfunction

      // Compare one returned distance with the oldest one pending.
      function void check_distance(logic [OUT_W-1:0] got);
         logic [OUT_W-1:0] want;
         if (pending_dist.size() == 0) begin
            $display("%0t: unexpected distance word, expected none, actual %0d", $time, got);
            errors++;
            return;
         end
         want = pending_dist.pop_front();
         if (got !== want) begin
            $display("%0t: distance mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [LAT_W-1:0] req_target_latitude;
   logic signed [LON_W-1:0] req_target_longitude;
   logic [OUT_W-1:0] rsp_distance;
   logic psel, penable, pwrite, pready;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;

   distance_scoreboard board;
   bit quiet_tail;
   int cycle_count;

   equirectangular_distance_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_target_latitude(req_target_latitude),
      .req_target_longitude(req_target_longitude),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_distance(rsp_distance),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check every accepted response word at the clock edge it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_distance(rsp_distance);
   end

   // Stall the response side in random bursts; keep it open in the tail.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("[equirectangular_distance_core] ERROR");
         $finish;
      end
   end

   // Write one reference register: setup phase, access phase, then the bus goes idle.
   task automatic write_reg(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock iff pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_REF_LAT) board.ref_lat = data[LAT_W-1:0];
      else board.ref_lon = data[LON_W-1:0];
      @(posedge clock);
   endtask

   // Move the reference point; drain the pipeline first.
   task automatic set_reference(logic [31:0] lat, logic [31:0] lon);
      wait_drained();
      write_reg(ADDR_REF_LAT, lat);
      write_reg(ADDR_REF_LON, lon);
   endtask

   task automatic wait_drained();
      while (board.pending_dist.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Offer one target word, holding it until accepted; idle in random bursts.
   task automatic send_target(logic [LAT_W-1:0] lat, logic [LON_W-1:0] lon);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_latitude <= lat;
      req_target_longitude <= lon;
      @(posedge clock iff req_ready);
      board.note_target(lat, lon);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [LAT_W-1:0] rand_lat(bit any_bits);
      if (any_bits) return LAT_W'($urandom);
      return LAT_W'($signed($urandom_range(0, 2 * 94371840)) - 94371840);
   endfunction

   function automatic logic [LON_W-1:0] rand_lon(bit any_bits);
      if (any_bits) return LON_W'($urandom);
      return LON_W'($signed($urandom_range(0, 2 * 188743680)) - 188743680);
   endfunction

   initial begin
      board = new();
      quiet_tail = 1'b0;
      cycle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_target_latitude = '0;
      req_target_longitude = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero, extremes, poles, antimeridian, 45-degree switch, raw bit patterns.
      send_target('0, '0);
      send_target(LAT_MAX, '0);
      send_target(-LAT_MAX, '0);
      send_target('0, LON_MAX);
      send_target('0, -LON_MAX);
      send_target(LAT_MAX, LON_MAX);
      send_target(-LAT_MAX, -LON_MAX);
      send_target(28'sd94371840 >>> 1, 29'sd1);
      send_target(LAT_W'((28'sd94371840 >>> 1) + 1), -29'sd1);
      send_target({1'b0, {(LAT_W-1){1'b1}}}, {1'b0, {(LON_W-1){1'b1}}});
      send_target({1'b1, {(LAT_W-1){1'b0}}}, {1'b1, {(LON_W-1){1'b0}}});
      send_target('1, '1);
      end_burst();
      set_reference(32'(-94371840), 32'(188743680));
      send_target(LAT_MAX, -LON_MAX);
      send_target(-LAT_MAX, LON_MAX);
      send_target('0, '0);
      end_burst();
      // High bits above the field width are dropped by the register.
      set_reference(32'hFFFF_FFFF, 32'hA000_0001);
      send_target({1'b1, {(LAT_W-1){1'b0}}}, {1'b0, {(LON_W-1){1'b1}}});
      send_target('0, '0);
      end_burst();

      // Random phases with new reference points, extremes among them.
      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0: set_reference('0, '0);
            1: set_reference(32'(94371840), 32'(-188743680));
            2: set_reference(32'(-94371840), 32'(-188743680));
            default: set_reference($urandom, $urandom);
         endcase
         if (phase == 10) quiet_tail = 1'b1;
         for (int n = 0; n < 150; n++)
            send_target(rand_lat($urandom_range(0, 9) == 0), rand_lon($urandom_range(0, 9) == 0));
         end_burst();
      end

      wait_drained();
      if (board.errors == 0 && board.pending_dist.size() == 0) begin
         $display("[equirectangular_distance_core] OK");
      end else begin
         $display("[equirectangular_distance_core] ERROR");
      end
      $finish;
   end

endmodule
